// ===== hdl/kperm_pkg.sv =====
package kperm_pkg;

    // Value range and selection geometry
    localparam int MAX_VALUES = 8;
    localparam int POSITIONS  = 8;
    localparam int VAL_W      = 4;
    localparam int CMP_W      = VAL_W + 1;
    localparam int CNT_W      = 4;
    localparam int POS_IDX_W  = 3;

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    localparam logic [CFG_IDX_W-1:0] REG_VALUE_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] VALUE_COUNT_RST = 4'd4;
    localparam logic [CFG_DATA_W-1:0] PICK_COUNT_RST  = 4'd2;

    // Largest usable n: limited by the value range and by the 4-bit pick fields
    localparam logic [VAL_W-1:0] N_CAP = (MAX_VALUES > 15) ? 4'd15 : VAL_W'(MAX_VALUES);
    localparam logic [CNT_W-1:0] M_CAP = CNT_W'(POSITIONS);

    typedef logic [MAX_VALUES-1:0] mask_t;
    typedef logic [VAL_W-1:0]      val_t;
    typedef logic [CNT_W-1:0]      cnt_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_BACK,
        S_FILL,
        S_EMIT
    } seq_state_t;

    typedef struct packed {
        logic go;
        logic restart;
        val_t n;
        cnt_t m;
    } kperm_req_t;

    typedef struct packed {
        logic [POSITIONS-1:0][VAL_W-1:0] picks;
        logic                            final_pick;
        logic                            exhausted;
    } kperm_result_t;

    // One-hot mask bit for value v (bit v-1); zero for v = 0
    function automatic mask_t value_bit(val_t v);
        mask_t m;
        m = '0;
        for (int k = 0; k < MAX_VALUES; k++)
        begin
            m[k] = ({1'b0, v} == CMP_W'(k + 1));
        end
        return m;
    endfunction

endpackage

// ===== hdl/kperm_find.sv =====
module kperm_find (
    input  kperm_pkg::mask_t mask,
    input  kperm_pkg::val_t  floor_val,
    input  kperm_pkg::val_t  limit,
    output logic             found,
    output kperm_pkg::val_t  value
);
    import kperm_pkg::*;

    // Smallest free value above floor_val and not above limit
    always_comb
    begin
        found = 1'b0;
        value = '0;
        for (int k = MAX_VALUES - 1; k >= 0; k--)
        begin
            if (!mask[k] && (CMP_W'(k + 1) > {1'b0, floor_val})
                && (CMP_W'(k + 1) <= {1'b0, limit}))
            begin
                found = 1'b1;
                value = VAL_W'(k + 1);
            end
        end
    end

endmodule

// ===== hdl/kperm_seq.sv =====
module kperm_seq (
    input  logic                     clk,
    input  logic                     rst_n,
    input  kperm_pkg::kperm_req_t    req,
    input  logic                     cfg_clear,
    input  logic                     res_take,
    output logic                     busy,
    output logic                     res_valid,
    output kperm_pkg::kperm_result_t result
);
    import kperm_pkg::*;

    seq_state_t                      state_reg, state_next;
    logic [POSITIONS-1:0][VAL_W-1:0] sel_reg, sel_next;
    mask_t                           mask_reg, mask_next;
    cnt_t                            walk_reg, walk_next;
    cnt_t                            pos_reg, pos_next;
    logic                            started_reg, started_next;
    logic                            done_reg, done_next;
    logic                            exh_reg, exh_next;

    cnt_t                   pos_dec;
    logic [POS_IDX_W-1:0]   back_idx;
    logic [POS_IDX_W-1:0]   fill_idx;
    val_t                   cur_val;
    mask_t                  released;
    mask_t                  find_mask;
    val_t                   find_floor;
    logic                   find_found;
    val_t                   find_value;
    logic                   is_last;

    assign pos_dec  = pos_reg - 1'b1;
    assign back_idx = pos_dec[POS_IDX_W-1:0];
    assign fill_idx = pos_reg[POS_IDX_W-1:0];
    assign cur_val  = sel_reg[back_idx];
    assign released = mask_reg & ~value_bit(cur_val);

    // Walking back: release the current value and look above it.
    // Filling: take the smallest free value.
    assign find_mask  = (state_reg == S_BACK) ? released : mask_reg;
    assign find_floor = (state_reg == S_BACK) ? cur_val : '0;

    kperm_find u_find (
        .mask      (find_mask),
        .floor_val (find_floor),
        .limit     (req.n),
        .found     (find_found),
        .value     (find_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            sel_reg     <= '0;
            mask_reg    <= '0;
            walk_reg    <= '0;
            pos_reg     <= '0;
            started_reg <= 1'b0;
            done_reg    <= 1'b0;
            exh_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            sel_reg     <= sel_next;
            mask_reg    <= mask_next;
            walk_reg    <= walk_next;
            pos_reg     <= pos_next;
            started_reg <= started_next;
            done_reg    <= done_next;
            exh_reg     <= exh_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        mask_next    = mask_reg;
        walk_next    = walk_reg;
        pos_next     = pos_reg;
        started_next = started_reg;
        done_next    = done_reg;
        exh_next     = exh_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    if (req.restart)
                    begin
                        sel_next     = '0;
                        mask_next    = '0;
                        walk_next    = req.m;
                        pos_next     = '0;
                        started_next = 1'b1;
                        if (req.m > CNT_W'(req.n))
                        begin
                            done_next  = 1'b1;
                            exh_next   = 1'b1;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            done_next  = 1'b0;
                            exh_next   = 1'b0;
                            state_next = S_FILL;
                        end
                    end
                    else if (!started_reg || done_reg)
                    begin
                        exh_next   = 1'b1;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        exh_next   = 1'b0;
                        pos_next   = walk_reg;
                        state_next = S_BACK;
                    end
                end
            end

            S_BACK:
            begin
                if (pos_reg == '0)
                begin
                    sel_next   = '0;
                    mask_next  = '0;
                    done_next  = 1'b1;
                    exh_next   = 1'b1;
                    state_next = S_EMIT;
                end
                else if (find_found)
                begin
                    sel_next[back_idx] = find_value;
                    mask_next          = released | value_bit(find_value);
                    state_next         = S_FILL;
                end
                else
                begin
                    sel_next[back_idx] = '0;
                    mask_next          = released;
                    pos_next           = pos_dec;
                end
            end

            S_FILL:
            begin
                if ((pos_reg >= walk_reg) || !find_found)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    sel_next[fill_idx] = find_value;
                    mask_next          = mask_reg | value_bit(find_value);
                    pos_next           = pos_reg + 1'b1;
                end
            end

            S_EMIT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_clear)
        begin
            started_next = 1'b0;
            done_next    = 1'b0;
        end
    end

    // Last selection in order is n, n-1, ..., n-m+1
    always_comb
    begin
        is_last = 1'b1;
        for (int j = 0; j < POSITIONS; j++)
        begin
            if ((CNT_W'(j) < walk_reg)
                && (({1'b0, sel_reg[j]} + CMP_W'(j)) != {1'b0, req.n}))
            begin
                is_last = 1'b0;
            end
        end
    end

    always_comb
    begin
        for (int j = 0; j < POSITIONS; j++)
        begin
            result.picks[j] = (!exh_reg && (CNT_W'(j) < walk_reg)) ? sel_reg[j] : '0;
        end
        result.final_pick = !exh_reg && is_last;
        result.exhausted  = exh_reg;
    end

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_EMIT);

    a_mask_matches_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !exh_reg) |-> ($countones(mask_reg) == walk_reg))
        else $error("in-use mask does not match selection length");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BACK || state_reg == S_FILL) |-> (pos_reg <= walk_reg))
        else $error("walk position beyond selection length");

    a_done_clears_mask: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (mask_reg == '0))
        else $error("exhausted walk left values in use");

    a_done_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
        !started_reg |-> !done_reg)
        else $error("exhausted flag set without a started walk");

endmodule

// ===== hdl/k_permutation_generator.sv =====
// Lexicographic k-permutation generator. Each input transaction either restarts
// the walk (restart = 1, giving 1, 2, ..., m) or asks for the next ordered
// selection of m distinct values from 1..n (restart = 0). n and m come from the
// value_count and pick_count registers, capped at 8; writing either register
// ends the current walk, and requests then report exhausted until a restart.
// Each transaction yields exactly one result: pick_0..pick_7 hold the
// selection (0 beyond position m-1), final_pick marks the last selection in
// order, and exhausted marks a request with nothing left (picks then 0). A
// request before any restart, or a restart with m > n, reports exhausted.
// Timing: one shared find-first-free unit handles one position per cycle. A
// restart fills positions 0..m-1 in turn; an advance walks back to the pivot
// position and then refills forward, or reports exhausted when it runs off
// the last selection; a request with no walk to advance reports exhausted
// without walking. in_stall stays high while a transaction is being worked,
// and drops again once its result has moved into the output register, so the
// next transaction is taken while that result still waits.
module k_permutation_generator (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [kperm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [kperm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                restart,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [kperm_pkg::VAL_W-1:0]         pick_0,
    output logic [kperm_pkg::VAL_W-1:0]         pick_1,
    output logic [kperm_pkg::VAL_W-1:0]         pick_2,
    output logic [kperm_pkg::VAL_W-1:0]         pick_3,
    output logic [kperm_pkg::VAL_W-1:0]         pick_4,
    output logic [kperm_pkg::VAL_W-1:0]         pick_5,
    output logic [kperm_pkg::VAL_W-1:0]         pick_6,
    output logic [kperm_pkg::VAL_W-1:0]         pick_7,
    output logic                                final_pick,
    output logic                                exhausted
);
    import kperm_pkg::*;

    logic [CFG_DATA_W-1:0] value_count_reg, value_count_next;
    logic [CFG_DATA_W-1:0] pick_count_reg, pick_count_next;
    logic                  cfg_clear;

    val_t          eff_n;
    cnt_t          eff_m;
    kperm_req_t    req;
    logic          busy;
    logic          res_valid;
    logic          res_take;
    kperm_result_t result;

    logic          out_valid_reg, out_valid_next;
    kperm_result_t out_reg;

    // Configuration: take writes, and end the walk on any register write
    always_comb
    begin
        value_count_next = value_count_reg;
        pick_count_next  = pick_count_reg;
        cfg_clear        = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VALUE_COUNT:
                begin
                    value_count_next = cfg_data;
                    cfg_clear        = 1'b1;
                end
                REG_PICK_COUNT:
                begin
                    pick_count_next = cfg_data;
                    cfg_clear       = 1'b1;
                end
                default:
                begin
                    cfg_clear = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_count_reg <= VALUE_COUNT_RST;
            pick_count_reg  <= PICK_COUNT_RST;
        end
        else
        begin
            value_count_reg <= value_count_next;
            pick_count_reg  <= pick_count_next;
        end
    end

    // Clamp oversized n and m
    assign eff_n = (VAL_W'(value_count_reg) > N_CAP) ? N_CAP : VAL_W'(value_count_reg);
    assign eff_m = (CNT_W'(pick_count_reg) > M_CAP) ? M_CAP : CNT_W'(pick_count_reg);

    // Accept a transaction only while the sequencer is idle
    assign in_stall = busy;
    assign req      = '{go: in_valid && !busy, restart: restart, n: eff_n, m: eff_m};

    kperm_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_clear (cfg_clear),
        .res_take  (res_take),
        .busy      (busy),
        .res_valid (res_valid),
        .result    (result)
    );

    // Output register: load when empty or being drained this cycle
    assign res_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (res_valid && res_take)
        begin
            out_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign pick_0     = out_reg.picks[0];
    assign pick_1     = out_reg.picks[1];
    assign pick_2     = out_reg.picks[2];
    assign pick_3     = out_reg.picks[3];
    assign pick_4     = out_reg.picks[4];
    assign pick_5     = out_reg.picks[5];
    assign pick_6     = out_reg.picks[6];
    assign pick_7     = out_reg.picks[7];
    assign final_pick = out_reg.final_pick;
    assign exhausted  = out_reg.exhausted;

endmodule
